// File: sv/iba_pkg.sv
`timescale 1ns / 1ps

package iba_pkg;

    // Default table size and the span that an 8-bit granted index can reach
    localparam int NUM_SLOTS_DEF = 256;
    localparam int INDEX_SPAN    = 256;

    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FREE_RD,
        S_FREE_WR,
        S_RESP
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load_item;
        logic    scan_clr;
        logic    scan_inc;
        logic    rd_scan;
        logic    rd_free;
        logic    wr_alloc;
        logic    wr_free;
        logic    load_result;
        status_t result_status;
    } ctrl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_free;
        logic range_err;
        logic hit;
        logic scan_last;
    } stat_t;

    // Bits of one bitmap byte that lie below the grant limit
    function automatic logic [7:0] byte_mask(input int base, input int limit);
        logic [7:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            m[b] = ((base + b) < limit);
        end
        return m;
    endfunction

endpackage

// File: sv/iba_ctrl.sv
`timescale 1ns / 1ps

module iba_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  iba_pkg::stat_t stat,
    output iba_pkg::ctrl_t ctrl
);

    iba_pkg::state_t state_reg;
    iba_pkg::state_t state_next;

    // Hold the current state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= iba_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            iba_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = iba_pkg::S_DECODE;
                end
            end
            iba_pkg::S_DECODE: begin
                priority if (stat.is_free && stat.range_err) begin
                    state_next = iba_pkg::S_RESP;
                end else if (stat.is_free) begin
                    state_next = iba_pkg::S_FREE_RD;
                end else begin
                    state_next = iba_pkg::S_SCAN_RD;
                end
            end
            iba_pkg::S_SCAN_RD: begin
                state_next = iba_pkg::S_SCAN_CHK;
            end
            iba_pkg::S_SCAN_CHK: begin
                if (stat.hit || stat.scan_last) begin
                    state_next = iba_pkg::S_RESP;
                end else begin
                    state_next = iba_pkg::S_SCAN_RD;
                end
            end
            iba_pkg::S_FREE_RD: begin
                state_next = iba_pkg::S_FREE_WR;
            end
            iba_pkg::S_FREE_WR: begin
                state_next = iba_pkg::S_RESP;
            end
            iba_pkg::S_RESP: begin
                if (m_tready) begin
                    state_next = iba_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = iba_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        ctrl               = '0;
        ctrl.result_status = iba_pkg::ST_OK;
        s_tready           = 1'b0;
        m_tvalid           = 1'b0;
        unique case (state_reg)
            iba_pkg::S_IDLE: begin
                s_tready       = 1'b1;
                ctrl.load_item = s_tvalid;
                ctrl.scan_clr  = s_tvalid;
            end
            iba_pkg::S_DECODE: begin
                if (stat.is_free && stat.range_err) begin
                    ctrl.load_result   = 1'b1;
                    ctrl.result_status = iba_pkg::ST_RANGE;
                end
            end
            iba_pkg::S_SCAN_RD: begin
                ctrl.rd_scan = 1'b1;
            end
            iba_pkg::S_SCAN_CHK: begin
                priority if (stat.hit) begin
                    ctrl.wr_alloc      = 1'b1;
                    ctrl.load_result   = 1'b1;
                    ctrl.result_status = iba_pkg::ST_OK;
                end else if (stat.scan_last) begin
                    ctrl.load_result   = 1'b1;
                    ctrl.result_status = iba_pkg::ST_FULL;
                end else begin
                    ctrl.scan_inc = 1'b1;
                end
            end
            iba_pkg::S_FREE_RD: begin
                ctrl.rd_free = 1'b1;
            end
            iba_pkg::S_FREE_WR: begin
                ctrl.wr_free       = 1'b1;
                ctrl.load_result   = 1'b1;
                ctrl.result_status = iba_pkg::ST_OK;
            end
            iba_pkg::S_RESP: begin
                m_tvalid = 1'b1;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

endmodule

// File: sv/iba_datapath.sv
`timescale 1ns / 1ps

module iba_datapath #(
    parameter int NUM_SLOTS = iba_pkg::NUM_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_cmd,
    input  logic [iba_pkg::INDEX_W-1:0]   in_slot_index,
    input  iba_pkg::ctrl_t                ctrl,
    output iba_pkg::stat_t                stat,
    output iba_pkg::status_t              out_status,
    output logic [iba_pkg::INDEX_W-1:0]   out_granted_index
);

    // Only slots below the 8-bit index span can ever be granted, so only
    // their bytes are stored; higher slots always read as free.
    localparam int GRANT_LIMIT = (NUM_SLOTS < iba_pkg::INDEX_SPAN) ?
                                 NUM_SLOTS : iba_pkg::INDEX_SPAN;
    localparam int GRANT_BYTES = (GRANT_LIMIT + 7) / 8;
    localparam int AW          = (GRANT_BYTES > 1) ? $clog2(GRANT_BYTES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(GRANT_BYTES - 1);

    logic [7:0]                  used_mem [GRANT_BYTES];
    logic [GRANT_BYTES-1:0]      valid_reg;
    logic [7:0]                  rd_data_reg;
    logic                        cmd_reg;
    logic [iba_pkg::INDEX_W-1:0] idx_reg;
    logic [AW-1:0]               scan_addr_reg;
    iba_pkg::status_t            status_reg;
    logic [iba_pkg::INDEX_W-1:0] granted_reg;

    logic [AW-1:0] free_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    free_bits;
    logic          hit;
    logic [2:0]    hit_bit;
    logic [7:0]    hit_onehot;
    logic [7:0]    clr_onehot;
    logic [iba_pkg::INDEX_W-1:0] grant_index;

    assign free_addr = AW'(idx_reg[iba_pkg::INDEX_W-1:3]);
    assign rd_addr   = ctrl.rd_free ? free_addr : scan_addr_reg;

    // Latch the item and step the scan pointer
    always_ff @(posedge aclk) begin
        if (ctrl.load_item) begin
            cmd_reg <= in_cmd;
            idx_reg <= in_slot_index;
        end
        if (!aresetn) begin
            scan_addr_reg <= '0;
        end else if (ctrl.scan_clr) begin
            scan_addr_reg <= '0;
        end else if (ctrl.scan_inc) begin
            scan_addr_reg <= scan_addr_reg + 1'b1;
        end
    end

    // Find the lowest free bit of the byte just read
    always_comb begin
        free_bits = ~rd_data_reg & iba_pkg::byte_mask(int'(scan_addr_reg) * 8, GRANT_LIMIT);
        hit       = 1'b0;
        hit_bit   = '0;
        for (int b = 7; b >= 0; b--) begin
            if (free_bits[b]) begin
                hit     = 1'b1;
                hit_bit = 3'(b);
            end
        end
        hit_onehot  = 8'(1) << hit_bit;
        clr_onehot  = 8'(1) << idx_reg[2:0];
        grant_index = iba_pkg::INDEX_W'({scan_addr_reg, hit_bit});
    end

    // Bitmap storage: registered read, entries not yet written read as free
    always_ff @(posedge aclk) begin
        if (ctrl.rd_scan || ctrl.rd_free) begin
            rd_data_reg <= valid_reg[rd_addr] ? used_mem[rd_addr] : 8'h00;
        end
        if (ctrl.wr_alloc) begin
            used_mem[scan_addr_reg] <= rd_data_reg | hit_onehot;
        end else if (ctrl.wr_free) begin
            used_mem[free_addr] <= rd_data_reg & ~clr_onehot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctrl.wr_alloc) begin
            valid_reg[scan_addr_reg] <= 1'b1;
        end else if (ctrl.wr_free) begin
            valid_reg[free_addr] <= 1'b1;
        end
    end

    // Capture the result item
    always_ff @(posedge aclk) begin
        if (ctrl.load_result) begin
            status_reg  <= ctrl.result_status;
            granted_reg <= ctrl.wr_alloc ? grant_index : '0;
        end
    end

    assign stat.is_free   = (cmd_reg == iba_pkg::CMD_FREE);
    assign stat.range_err = (32'(idx_reg) >= 32'(NUM_SLOTS));
    assign stat.hit       = hit;
    assign stat.scan_last = (scan_addr_reg == LAST_ADDR);

    assign out_status        = status_reg;
    assign out_granted_index = granted_reg;

endmodule

// File: sv/inode_bitmap_allocator_core.sv
`timescale 1ns / 1ps

// First-free slot allocator over a bitmap of NUM_SLOTS slots.
// Input channel (s_): s_tuser carries the command (0 allocate, 1 free),
// s_tdata carries the slot index to free (ignored for allocate).
// Result channel (m_): m_tuser carries the status (0 ok, 1 full, 2 index
// out of range), m_tdata carries the granted slot index (zero unless an
// allocate succeeded). Every item gives exactly one result item.
// One item is handled at a time; s_tready is high only while idle.
// After accept, a free reads its bitmap byte and writes it back (a range
// error goes straight to the result); an allocate scans bitmap bytes (1 up
// to 32 examined), reading each and then checking it, as the single-port
// bitmap memory is read one byte at a time by the scan loop. The next item
// is taken the cycle after the result is accepted.
// Reset (aresetn low, synchronous) marks every slot free at once and
// returns the controller to idle; no clearing pass is needed.
// When the receiver stalls, m_tvalid and the result stay held and no new
// item is accepted until m_tready is seen.
module inode_bitmap_allocator_core #(
    parameter int NUM_SLOTS = iba_pkg::NUM_SLOTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // [7:0] slot_index
    input  logic                                s_tuser,  // [0] cmd
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,  // [7:0] granted_index
    output logic [iba_pkg::STATUS_W-1:0]        m_tuser   // [1:0] status
);

    iba_pkg::ctrl_t   ctrl;
    iba_pkg::stat_t   stat;
    iba_pkg::status_t out_status;

    iba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    iba_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_cmd            (s_tuser),
        .in_slot_index     (s_tdata),
        .ctrl              (ctrl),
        .stat              (stat),
        .out_status        (out_status),
        .out_granted_index (m_tdata)
    );

    assign m_tuser = out_status;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import iba_pkg::*;

    localparam int NUM_SLOTS   = NUM_SLOTS_DEF;
    localparam int GRANT_LIMIT = (NUM_SLOTS < INDEX_SPAN) ? NUM_SLOTS : INDEX_SPAN;
    localparam int RAND_PER_PHASE = 330;
    localparam int DRAIN_CYCLES   = 100;
    localparam longint CYCLE_LIMIT = 1500000;

    // One reply of the allocator: status in tuser, granted slot in tdata
    typedef struct packed {
        status_t    status;
        logic [7:0] granted;
    } slot_reply_t;

    // One directed request, with its reply typed in where it is obvious
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] slot;
        logic       typed;
        status_t    status;
        logic [7:0] granted;
    } slot_req_t;

    localparam int N_DIRECTED = 20;
    localparam slot_req_t DIRECTED[N_DIRECTED] = '{
        '{CMD_ALLOC, 8'h00, 1'b1, ST_OK, 8'd0},   // first grant after reset
        '{CMD_ALLOC, 8'hFF, 1'b1, ST_OK, 8'd1},   // slot field ignored on allocate
        '{CMD_ALLOC, 8'h55, 1'b1, ST_OK, 8'd2},
        '{CMD_FREE,  8'h01, 1'b1, ST_OK, 8'd0},
        '{CMD_ALLOC, 8'h00, 1'b0, ST_OK, 8'd0},   // hole at slot 1 is refilled
        '{CMD_FREE,  8'hC8, 1'b1, ST_OK, 8'd0},   // free of a slot never used
        '{CMD_FREE,  8'hFF, 1'b1, ST_OK, 8'd0},   // top slot
        '{CMD_FREE,  8'h00, 1'b1, ST_OK, 8'd0},   // bottom slot
        '{CMD_ALLOC, 8'hAA, 1'b0, ST_OK, 8'd0},
        '{CMD_FREE,  8'h02, 1'b1, ST_OK, 8'd0},
        '{CMD_FREE,  8'h02, 1'b1, ST_OK, 8'd0},   // second free of the same slot
        '{CMD_ALLOC, 8'h00, 1'b0, ST_OK, 8'd0},
        '{CMD_ALLOC, 8'h00, 1'b0, ST_OK, 8'd0},
        '{CMD_ALLOC, 8'h00, 1'b0, ST_OK, 8'd0},
        '{CMD_ALLOC, 8'h00, 1'b0, ST_OK, 8'd0},
        '{CMD_ALLOC, 8'h00, 1'b0, ST_OK, 8'd0},
        '{CMD_ALLOC, 8'h00, 1'b0, ST_OK, 8'd0},   // fills the last slot of the first byte
        '{CMD_ALLOC, 8'h00, 1'b0, ST_OK, 8'd0},
        '{CMD_FREE,  8'h07, 1'b0, ST_OK, 8'd0},
        '{CMD_ALLOC, 8'h00, 1'b0, ST_OK, 8'd0}
    };

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = 8'h00;  // [7:0] slot_index
    logic                s_tuser  = 1'b0;   // [0] cmd
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;           // [7:0] granted_index
    logic [STATUS_W-1:0] m_tuser;           // [1:0] status

    logic [NUM_SLOTS-1:0] used_map;
    slot_reply_t          reply_q[$];
    int                   err_count     = 0;
    int                   send_idle_pct = 33;
    int                   recv_idle_pct = 80;
    longint               cycle_count   = 0;

    inode_bitmap_allocator_core #(
        .NUM_SLOTS(NUM_SLOTS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Apply one request to the shadow bitmap and return the reply it gives
    function automatic slot_reply_t alloc_first_free(input cmd_t cmd, input logic [7:0] slot);
        slot_reply_t r;
        r.status  = ST_OK;
        r.granted = '0;
        if (cmd == CMD_ALLOC) begin
            r.status = ST_FULL;
            for (int s = 0; s < GRANT_LIMIT; s++) begin
                if (!used_map[s]) begin
                    used_map[s] = 1'b1;
                    r.granted   = s[7:0];
                    r.status    = ST_OK;
                    break;
                end
            end
        end else if (int'(slot) >= NUM_SLOTS) begin
            r.status = ST_RANGE;
        end else begin
            used_map[slot] = 1'b0;
        end
        return r;
    endfunction

    // Offer one request, hold it until taken, then queue its reply
    task automatic send_request(input slot_req_t req, output status_t st);
        slot_reply_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.cmd;
        s_tdata  <= req.slot;
        do @(posedge aclk); while (!s_tready);
        r = alloc_first_free(req.cmd, req.slot);
        if (req.typed) begin
            r.status  = req.status;
            r.granted = req.granted;
        end
        reply_q = {reply_q, r};
        st = r.status;
    endtask

    // Stall the result channel at random and check each reply taken
    always @(posedge aclk) begin
        slot_reply_t want;
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (reply_q.size() == 0) begin
                $error("unexpected reply: status %0d granted_index %0d", m_tuser, m_tdata);
                err_count++;
            end else begin
                want = reply_q.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    err_count++;
                end
                if (m_tdata !== want.granted) begin
                    $error("granted_index: expected %0d, got %0d", want.granted, m_tdata);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        slot_req_t req;
        status_t   st;
        logic      fill_mode;
        int        full_hits;
        int        drain_left;

        used_map   = '0;
        fill_mode  = 1'b1;
        full_hits  = 0;
        drain_left = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_request(DIRECTED[i], st);
        end

        // Random part: fill until full is seen a few times, then drain a while
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 80 : 0;
            recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 33 : 0;
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (fill_mode) begin
                    req.cmd = ($urandom_range(99) < 90) ? CMD_ALLOC : CMD_FREE;
                end else begin
                    req.cmd = ($urandom_range(99) < 80) ? CMD_FREE : CMD_ALLOC;
                end
                req.slot    = 8'($urandom_range(255));
                req.typed   = 1'b0;
                req.status  = ST_OK;
                req.granted = '0;
                send_request(req, st);
                if (fill_mode) begin
                    if (st == ST_FULL) begin
                        full_hits++;
                    end
                    if (full_hits >= 3) begin
                        fill_mode  = 1'b0;
                        full_hits  = 0;
                        drain_left = $urandom_range(20, 120);
                    end
                end else begin
                    drain_left--;
                    if (drain_left <= 0) begin
                        fill_mode = 1'b1;
                    end
                end
            end
        end
        s_tvalid <= 1'b0;

        // Wait for every reply, then watch for strays
        while (reply_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
